// ===== src/ultrasonic_echo_ranger_top_defines.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shared concurrent assertion forms used by the ranger RTL.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UER_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ranger assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UER_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ranger assertion failed");

`endif

// ===== src/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Constants, phase codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

    localparam int ECHO_COUNT_WIDTH_DEF = 16;
    localparam int TIMING_WIDTH_DEF     = 10;
    localparam int CFG_WIDTH            = 10;
    localparam int CFG_INDEX_WIDTH      = 3;
    localparam int DIST_WIDTH           = 18;
    localparam int FRAC_BITS            = 8;
    localparam int CM_SCALE_WIDTH       = 11;
    localparam int CM_PER_US_Q16        = 1114;

    localparam logic [CFG_WIDTH-1:0] PRE_LOW_RESET   = 10'd20;
    localparam logic [CFG_WIDTH-1:0] TRIG_HIGH_RESET = 10'd12;
    localparam logic [CFG_WIDTH-1:0] POST_LOW_RESET  = 10'd20;
    localparam logic [CFG_WIDTH-1:0] PERIOD_RESET    = 10'd1;
    localparam logic [CFG_WIDTH-1:0] MAX_DIST_RESET  = 10'd400;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRE_LOW   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRIG_HIGH = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POST_LOW  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PERIOD    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_DIST  = 3'd4;

    typedef logic [2:0] phase_t;

    localparam phase_t PH_IDLE = 3'd0;
    localparam phase_t PH_PRE  = 3'd1;
    localparam phase_t PH_HIGH = 3'd2;
    localparam phase_t PH_POST = 3'd3;
    localparam phase_t PH_WAIT = 3'd4;
    localparam phase_t PH_MEAS = 3'd5;
    localparam phase_t PH_MUL  = 3'd6;
    localparam phase_t PH_FIN  = 3'd7;

    typedef logic [1:0] tick_op_t;

    localparam tick_op_t TICK_HOLD = 2'd0;
    localparam tick_op_t TICK_CLR  = 2'd1;
    localparam tick_op_t TICK_SET1 = 2'd2;
    localparam tick_op_t TICK_INC  = 2'd3;

    typedef struct packed {
        logic pre;
        logic high;
        logic post;
    } timed_flags_t;

    typedef struct packed {
        tick_op_t tick_op;
        logic     meas_start;
        logic     meas_count;
        logic     mul1_load;
        logic     mul2_load;
        logic     out_load;
        logic     out_finish;
        logic     out_trig;
        logic     out_busy;
    } uer_cmd_t;

    typedef struct packed {
        logic         ticks_ge_cur;
        logic         inc_ge_cur;
        timed_flags_t len_zero;
        timed_flags_t len_le1;
    } uer_status_t;

endpackage

`default_nettype wire

// ===== src/ultrasonic_echo_ranger_top.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger pulse generator and echo width timer with distance conversion.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_start_req, s_echo_level
//   m_        out        m_valid/m_ready    m_trigger_level, m_busy_res, m_done_res,
//                                           m_valid_res, m_distance_q8
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// Each tick transaction yields one result transaction, registered in the cycle
// after acceptance. On the tick on which the echo falls, the result is instead
// registered after the PH_MUL and PH_FIN states of the two-stage distance
// multiplier, and input is held off in those states.
// A stalled output holds off input until the result is taken.
// Reset is synchronous and active low; configuration returns to its defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_top #(
    parameter int ECHO_COUNT_WIDTH = uer_pkg::ECHO_COUNT_WIDTH_DEF,
    parameter int TIMING_WIDTH     = uer_pkg::TIMING_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [uer_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [uer_pkg::CFG_WIDTH-1:0]       cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_start_req,
    input  wire logic                                s_echo_level,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_trigger_level,
    output logic                                     m_busy_res,
    output logic                                     m_done_res,
    output logic                                     m_valid_res,
    output logic [uer_pkg::DIST_WIDTH-1:0]           m_distance_q8
);

    uer_pkg::phase_t      phase;
    uer_pkg::uer_cmd_t    cmd;
    uer_pkg::uer_status_t status;

    uer_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_req  (s_start_req),
        .s_echo_level (s_echo_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .phase        (phase),
        .cmd          (cmd),
        .status       (status)
    );

    uer_datapath #(
        .ECHO_COUNT_WIDTH (ECHO_COUNT_WIDTH),
        .TIMING_WIDTH     (TIMING_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .phase           (phase),
        .cmd             (cmd),
        .status          (status),
        .m_trigger_level (m_trigger_level),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_valid_res     (m_valid_res),
        .m_distance_q8   (m_distance_q8)
    );

endmodule

`default_nettype wire

// ===== src/uer_datapath.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger datapath
// Configuration registers, phase tick counter, echo prescaler and counter,
// two-stage distance multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_datapath #(
    parameter int ECHO_COUNT_WIDTH = uer_pkg::ECHO_COUNT_WIDTH_DEF,
    parameter int TIMING_WIDTH     = uer_pkg::TIMING_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [uer_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [uer_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    input  wire uer_pkg::phase_t                      phase,
    input  wire uer_pkg::uer_cmd_t                    cmd,
    output uer_pkg::uer_status_t                      status,
    output logic                                      m_trigger_level,
    output logic                                      m_busy_res,
    output logic                                      m_done_res,
    output logic                                      m_valid_res,
    output logic [uer_pkg::DIST_WIDTH-1:0]            m_distance_q8
);

    localparam int CW  = uer_pkg::CFG_WIDTH;
    localparam int P1W = ECHO_COUNT_WIDTH + CW;
    localparam int P2W = P1W + uer_pkg::CM_SCALE_WIDTH;
    localparam int QW  = P2W - uer_pkg::FRAC_BITS;
    localparam int DW  = uer_pkg::DIST_WIDTH;

    logic [CW-1:0]               pre_low_reg;
    logic [CW-1:0]               trig_high_reg;
    logic [CW-1:0]               post_low_reg;
    logic [CW-1:0]               period_reg;
    logic [CW-1:0]               max_dist_reg;
    logic [TIMING_WIDTH-1:0]     ticks_reg, ticks_next;
    logic [CW-1:0]               prescale_reg, prescale_next;
    logic [ECHO_COUNT_WIDTH-1:0] count_reg, count_next;
    logic [P1W-1:0]              mul1_reg;
    logic [P2W-1:0]              mul2_reg;
    logic                        trig_reg, busy_reg, done_reg, valid_reg;
    logic [DW-1:0]               dist_reg;

    logic [TIMING_WIDTH-1:0]     pre_len, high_len, post_len, cur_len, ticks_inc;
    logic [CW-1:0]               period_eff, pre_base, pre_inc;
    logic [ECHO_COUNT_WIDTH-1:0] cnt_base;
    logic [QW-1:0]               q8, limit_q8;
    logic                        in_range;

    assign pre_len  = TIMING_WIDTH'(pre_low_reg);
    assign high_len = TIMING_WIDTH'(trig_high_reg);
    assign post_len = TIMING_WIDTH'(post_low_reg);

    always_comb begin
        unique case (phase)
            uer_pkg::PH_PRE:  cur_len = pre_len;
            uer_pkg::PH_HIGH: cur_len = high_len;
            default:          cur_len = post_len;
        endcase
    end

    assign ticks_inc = ticks_reg + TIMING_WIDTH'(1);

    assign status.ticks_ge_cur  = (ticks_reg >= cur_len);
    assign status.inc_ge_cur    = (ticks_inc >= cur_len);
    assign status.len_zero.pre  = (pre_len == '0);
    assign status.len_zero.high = (high_len == '0);
    assign status.len_zero.post = (post_len == '0);
    assign status.len_le1.pre   = (pre_len <= TIMING_WIDTH'(1));
    assign status.len_le1.high  = (high_len <= TIMING_WIDTH'(1));
    assign status.len_le1.post  = (post_len <= TIMING_WIDTH'(1));

    always_comb begin
        unique case (cmd.tick_op)
            uer_pkg::TICK_CLR:  ticks_next = '0;
            uer_pkg::TICK_SET1: ticks_next = TIMING_WIDTH'(1);
            uer_pkg::TICK_INC:  ticks_next = ticks_inc;
            default:            ticks_next = ticks_reg;
        endcase
    end

    assign period_eff = (period_reg == '0) ? CW'(1) : period_reg;
    assign pre_base   = cmd.meas_start ? '0 : prescale_reg;
    assign cnt_base   = cmd.meas_start ? '0 : count_reg;
    assign pre_inc    = pre_base + CW'(1);

    always_comb begin
        prescale_next = prescale_reg;
        count_next    = count_reg;
        if (cmd.meas_count) begin
            if (pre_inc >= period_eff) begin
                prescale_next = '0;
                count_next    = (cnt_base == '1) ? cnt_base
                                                 : cnt_base + ECHO_COUNT_WIDTH'(1);
            end else begin
                prescale_next = pre_inc;
                count_next    = cnt_base;
            end
        end
    end

    assign q8       = mul2_reg[P2W-1:uer_pkg::FRAC_BITS];
    assign limit_q8 = QW'({max_dist_reg, {uer_pkg::FRAC_BITS{1'b0}}});
    assign in_range = (q8 < limit_q8);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_low_reg   <= uer_pkg::PRE_LOW_RESET;
            trig_high_reg <= uer_pkg::TRIG_HIGH_RESET;
            post_low_reg  <= uer_pkg::POST_LOW_RESET;
            period_reg    <= uer_pkg::PERIOD_RESET;
            max_dist_reg  <= uer_pkg::MAX_DIST_RESET;
            ticks_reg     <= '0;
            prescale_reg  <= '0;
            count_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    uer_pkg::CFG_PRE_LOW:   pre_low_reg   <= cfg_wdata;
                    uer_pkg::CFG_TRIG_HIGH: trig_high_reg <= cfg_wdata;
                    uer_pkg::CFG_POST_LOW:  post_low_reg  <= cfg_wdata;
                    uer_pkg::CFG_PERIOD:    period_reg    <= cfg_wdata;
                    uer_pkg::CFG_MAX_DIST:  max_dist_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            ticks_reg    <= ticks_next;
            prescale_reg <= prescale_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul1_load) begin
            mul1_reg <= P1W'(count_reg) * P1W'(period_eff);
        end
        if (cmd.mul2_load) begin
            mul2_reg <= P2W'(mul1_reg) * P2W'(uer_pkg::CM_PER_US_Q16);
        end
        if (cmd.out_load) begin
            trig_reg  <= cmd.out_trig;
            busy_reg  <= cmd.out_busy;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
            dist_reg  <= '0;
        end else if (cmd.out_finish) begin
            trig_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b1;
            valid_reg <= in_range;
            dist_reg  <= in_range ? q8[DW-1:0] : '0;
        end
    end

    assign m_trigger_level = trig_reg;
    assign m_busy_res      = busy_reg;
    assign m_done_res      = done_reg;
    assign m_valid_res     = valid_reg;
    assign m_distance_q8   = dist_reg;

endmodule

`default_nettype wire

// ===== src/uer_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger controller
// Measurement phase sequencer, zero-length phase skipping and the
// input/output handshake control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ultrasonic_echo_ranger_top_defines.svh"

module uer_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_start_req,
    input  wire logic                 s_echo_level,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output uer_pkg::phase_t           phase,
    output uer_pkg::uer_cmd_t         cmd,
    input  wire uer_pkg::uer_status_t status
);

    uer_pkg::phase_t phase_reg, phase_next;
    logic            m_valid_reg, m_valid_next;

    uer_pkg::phase_t p0, eff;
    logic            accept, ge, fresh, last;

    function automatic logic sel_flag(input uer_pkg::timed_flags_t f,
                                      input uer_pkg::phase_t p);
        logic r;
        unique case (p)
            uer_pkg::PH_PRE:  r = f.pre;
            uer_pkg::PH_HIGH: r = f.high;
            uer_pkg::PH_POST: r = f.post;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_timed(input uer_pkg::phase_t p);
        return (p == uer_pkg::PH_PRE) || (p == uer_pkg::PH_HIGH) ||
               (p == uer_pkg::PH_POST);
    endfunction

    always_comb begin
        cmd          = '0;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg;
        ge           = 1'b0;

        s_ready = (phase_reg != uer_pkg::PH_MUL) && (phase_reg != uer_pkg::PH_FIN) &&
                  (!m_valid_reg || m_ready);
        accept  = s_valid && s_ready;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        p0 = (phase_reg == uer_pkg::PH_IDLE && s_start_req) ? uer_pkg::PH_PRE : phase_reg;
        if (is_timed(p0)) begin
            ge = (p0 != phase_reg) ? sel_flag(status.len_zero, p0) : status.ticks_ge_cur;
        end
        fresh = (p0 != phase_reg) || ge;

        eff = ge ? p0 + 3'd1 : p0;
        for (int i = 0; i < 2; i++) begin
            if (is_timed(eff) && sel_flag(status.len_zero, eff)) begin
                eff = eff + 3'd1;
            end
        end
        last = fresh ? sel_flag(status.len_le1, eff) : status.inc_ge_cur;

        if (accept) begin
            unique case (eff)
                uer_pkg::PH_PRE, uer_pkg::PH_HIGH, uer_pkg::PH_POST: begin
                    cmd.out_load = 1'b1;
                    cmd.out_busy = 1'b1;
                    cmd.out_trig = (eff == uer_pkg::PH_HIGH);
                    if (last) begin
                        phase_next  = eff + 3'd1;
                        cmd.tick_op = uer_pkg::TICK_CLR;
                    end else begin
                        phase_next  = eff;
                        cmd.tick_op = fresh ? uer_pkg::TICK_SET1 : uer_pkg::TICK_INC;
                    end
                end
                uer_pkg::PH_WAIT: begin
                    cmd.out_load = 1'b1;
                    cmd.out_busy = 1'b1;
                    cmd.tick_op  = uer_pkg::TICK_CLR;
                    phase_next   = uer_pkg::PH_WAIT;
                    if (s_echo_level) begin
                        phase_next     = uer_pkg::PH_MEAS;
                        cmd.meas_start = 1'b1;
                        cmd.meas_count = 1'b1;
                    end
                end
                uer_pkg::PH_MEAS: begin
                    if (s_echo_level) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_busy   = 1'b1;
                        cmd.meas_count = 1'b1;
                    end else begin
                        cmd.mul1_load = 1'b1;
                        phase_next    = uer_pkg::PH_MUL;
                    end
                end
                default: begin
                    cmd.out_load = 1'b1;
                    phase_next   = uer_pkg::PH_IDLE;
                end
            endcase
        end else if (phase_reg == uer_pkg::PH_MUL) begin
            cmd.mul2_load = 1'b1;
            phase_next    = uer_pkg::PH_FIN;
        end else if (phase_reg == uer_pkg::PH_FIN) begin
            cmd.out_finish = 1'b1;
            cmd.tick_op    = uer_pkg::TICK_CLR;
            phase_next     = uer_pkg::PH_IDLE;
        end

        if (cmd.out_load || cmd.out_finish) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= uer_pkg::PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign phase   = phase_reg;
    assign m_valid = m_valid_reg;

    `UER_ASSERT_NXT(a_fall_starts_mul, aclk, aresetn,
        accept && phase_reg == uer_pkg::PH_MEAS && !s_echo_level,
        phase_reg == uer_pkg::PH_MUL)
    `UER_ASSERT_NXT(a_mul_to_fin, aclk, aresetn,
        phase_reg == uer_pkg::PH_MUL, phase_reg == uer_pkg::PH_FIN)
    `UER_ASSERT_IMP(a_fin_slot_free, aclk, aresetn,
        phase_reg == uer_pkg::PH_FIN, !m_valid_reg)
    `UER_ASSERT_NXT(a_fin_delivers, aclk, aresetn,
        phase_reg == uer_pkg::PH_FIN, m_valid_reg && phase_reg == uer_pkg::PH_IDLE)

endmodule

`default_nettype wire
